>>> hdl/mwm_pkg.sv
// Shared definitions for the maze wall map: transaction payload types,
// mode and direction codes, sequencer states and the flag mask helper.
// No dependencies; imported by maze_wall_map and mwm_checker.
package mwm_pkg;

    // Request modes; any other code behaves as a query
    localparam logic [1:0] MODE_MARK   = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_DETECT = 2'd2;

    // Wall directions
    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [1:0] direction;
        logic       wall_present;
        logic [1:0] heading;
        logic       sensor_front;
        logic       sensor_left;
        logic       sensor_right;
    } req_item_t;

    typedef struct packed {
        logic known_wall;
        logic known_open;
        logic detected_wall;
        logic map_updated;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_OWN,
        ST_NB
    } mwm_state_t;

    // Wall flags sit in bits 3:0, open flags in bits 7:4
    function automatic logic [7:0] flag_mask(input logic wall, input logic [1:0] dir);
        return 8'b1 << {~wall, dir};
    endfunction

endpackage

>>> hdl/maze_wall_map.sv
// Maze wall map: one 8-bit flag entry per cell in a single synchronous RAM.
// Depends on mwm_pkg for payload types, codes and the sequencer state type.
//
// Sequencing: a query, or any request that writes no neighbour, queues its response
// from ST_OWN; a mark or detect with an in-grid neighbour queues it from ST_NB.
// Throughput: one request per cycle while the response queue has room; after one with
// a neighbour write the next waits for ST_NB, the single RAM write port doing
// read-modify-write of two cells. Reset: a clearing pass writes the border walls and
// the east wall of cell (0,0); no request is accepted until it completes.
module maze_wall_map #(
    parameter int GRID_SIDE = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mwm_pkg::req_item_t req_item,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output mwm_pkg::rsp_item_t rsp_item
);
    import mwm_pkg::*;

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COORD_W = $clog2(GRID_SIDE);
    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0]  ROW_STEP   = ADDR_W'(GRID_SIDE);
    localparam logic [ADDR_W-1:0]  COL_STEP   = ADDR_W'(1);
    localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(GRID_SIDE - 1);
    localparam logic [COORD_W-1:0] FIRST_COORD = '0;
    localparam logic [COORD_W-1:0] SECOND_COORD = COORD_W'(1);

    // Map RAM and its ports
    logic [7:0]        mem [CELLS];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // Sequencer and request context
    mwm_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] init_addr_reg;
    logic [COORD_W-1:0] init_x_reg, init_y_reg;
    logic [ADDR_W-1:0] cur_addr_reg, cur_nb_addr_reg;
    logic [1:0]        cur_dir_reg;
    logic              cur_wall_reg, cur_update_reg, cur_in_grid_reg;
    logic              cur_nb_ok_reg, cur_detected_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;
    rsp_item_t         res_reg;

    // Response queue, two entries
    rsp_item_t         q0_reg, q1_reg;
    logic [1:0]        occ_reg;
    logic [1:0]        occ_after;
    logic              push, pop, last_phase, accept;
    rsp_item_t         push_data, res_comb;

    // Request decode
    logic              req_in_grid, req_nb_inside, req_chosen, req_sensed;
    logic              req_update, req_wall;
    logic [1:0]        head_left, head_right;
    logic [ADDR_W-1:0] req_addr, req_nb_addr;

    logic [7:0]        rd_cur, own_new, init_flags;

    // Hold the map; read data is registered, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Decode the incoming request
    always_comb
    begin
        req_in_grid = (int'(req_item.cell_x) < GRID_SIDE) &&
                      (int'(req_item.cell_y) < GRID_SIDE);
        req_addr    = ADDR_W'(int'(req_item.cell_y) * GRID_SIDE + int'(req_item.cell_x));
        head_left   = req_item.heading + 2'd3;
        head_right  = req_item.heading + 2'd1;

        req_chosen = 1'b1;
        if (req_item.direction == req_item.heading)
        begin
            req_sensed = req_item.sensor_front;
        end
        else if (req_item.direction == head_left)
        begin
            req_sensed = req_item.sensor_left;
        end
        else if (req_item.direction == head_right)
        begin
            req_sensed = req_item.sensor_right;
        end
        else
        begin
            req_sensed = 1'b0;
            req_chosen = 1'b0;
        end

        case (req_item.mode)
            MODE_MARK:
            begin
                req_update = req_in_grid;
                req_wall   = req_item.wall_present;
            end
            MODE_DETECT:
            begin
                req_update = req_in_grid && req_chosen;
                req_wall   = req_sensed;
            end
            MODE_QUERY:
            begin
                req_update = 1'b0;
                req_wall   = 1'b0;
            end
            default:
            begin
                req_update = 1'b0;
                req_wall   = 1'b0;
            end
        endcase

        case (req_item.direction)
            DIR_NORTH:
            begin
                req_nb_inside = (int'(req_item.cell_y) + 1) < GRID_SIDE;
                req_nb_addr   = req_addr + ROW_STEP;
            end
            DIR_EAST:
            begin
                req_nb_inside = (int'(req_item.cell_x) + 1) < GRID_SIDE;
                req_nb_addr   = req_addr + COL_STEP;
            end
            DIR_SOUTH:
            begin
                req_nb_inside = req_item.cell_y != 4'd0;
                req_nb_addr   = req_addr - ROW_STEP;
            end
            default:
            begin
                req_nb_inside = req_item.cell_x != 4'd0;
                req_nb_addr   = req_addr - COL_STEP;
            end
        endcase
    end

    // Reset pattern of the cell under the clearing pass
    always_comb
    begin
        init_flags    = 8'h00;
        init_flags[0] = init_y_reg == LAST_COORD;
        init_flags[1] = (init_x_reg == LAST_COORD) ||
                        (init_x_reg == FIRST_COORD && init_y_reg == FIRST_COORD);
        init_flags[2] = init_y_reg == FIRST_COORD;
        init_flags[3] = (init_x_reg == FIRST_COORD) ||
                        (init_x_reg == SECOND_COORD && init_y_reg == FIRST_COORD);
    end

    // Handshake: accept when the response queue keeps a slot for this request
    assign last_phase = (state_reg == ST_OWN && !cur_nb_ok_reg) || (state_reg == ST_NB);
    assign push       = last_phase;
    assign pop        = rsp_valid && rsp_ready;
    assign occ_after  = occ_reg - 2'(pop) + 2'(push);
    assign req_ready  = (state_reg == ST_IDLE || last_phase) && (occ_after <= 2'd1);
    assign accept     = req_valid && req_ready;
    assign rsp_valid  = occ_reg != 2'd0;
    assign rsp_item   = q0_reg;

    // Forward a write that lands on the entry being read in the same cycle
    assign rd_cur  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign own_new = rd_cur | (cur_update_reg ? flag_mask(cur_wall_reg, cur_dir_reg) : 8'h00);

    always_comb
    begin
        res_comb.known_wall    = cur_in_grid_reg && own_new[{1'b0, cur_dir_reg}];
        res_comb.known_open    = cur_in_grid_reg && own_new[{1'b1, cur_dir_reg}];
        res_comb.detected_wall = cur_detected_reg;
        res_comb.map_updated   = cur_update_reg;
    end

    // Sequencer: next state and RAM port control
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_addr_reg;
        mem_wdata  = own_new;
        mem_raddr  = req_addr;
        push_data  = res_reg;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_addr_reg;
                mem_wdata = init_flags;
                if (init_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_OWN;
                end
            end
            ST_OWN:
            begin
                mem_we = cur_update_reg;
                if (cur_nb_ok_reg)
                begin
                    mem_raddr  = cur_nb_addr_reg;
                    state_next = ST_NB;
                end
                else
                begin
                    push_data  = res_comb;
                    state_next = accept ? ST_OWN : ST_IDLE;
                end
            end
            ST_NB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_nb_addr_reg;
                mem_wdata  = rd_cur | flag_mask(cur_wall_reg, cur_dir_reg ^ 2'd2);
                state_next = accept ? ST_OWN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Advance state, clearing pass counters, forwarding flag and queue count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            init_x_reg    <= '0;
            init_y_reg    <= '0;
            fwd_hit_reg   <= 1'b0;
            occ_reg       <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            fwd_hit_reg <= mem_we && (mem_waddr == mem_raddr);
            occ_reg     <= occ_after;
            if (state_reg == ST_INIT)
            begin
                init_addr_reg <= init_addr_reg + COL_STEP;
                if (init_x_reg == LAST_COORD)
                begin
                    init_x_reg <= '0;
                    init_y_reg <= init_y_reg + SECOND_COORD;
                end
                else
                begin
                    init_x_reg <= init_x_reg + SECOND_COORD;
                end
            end
        end
    end

    // Capture request context, forwarded data and responses
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= mem_wdata;
        if (accept)
        begin
            cur_addr_reg     <= req_addr;
            cur_nb_addr_reg  <= req_nb_addr;
            cur_dir_reg      <= req_item.direction;
            cur_wall_reg     <= req_wall;
            cur_update_reg   <= req_update;
            cur_in_grid_reg  <= req_in_grid;
            cur_nb_ok_reg    <= req_update && req_nb_inside;
            cur_detected_reg <= (req_item.mode == MODE_DETECT) && req_sensed;
        end
        if (state_reg == ST_OWN)
        begin
            res_reg <= res_comb;
        end
        // Place a new response at the head when the queue drains, else advance the head
        if (push && (occ_reg - 2'(pop) == 2'd0))
        begin
            q0_reg <= push_data;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
        if (push && (occ_reg - 2'(pop) != 2'd0))
        begin
            q1_reg <= push_data;
        end
    end

endmodule

>>> hdl/mwm_checker.sv
// Port-level checks for maze_wall_map, attached by the bind at the end.
// Depends on mwm_pkg for the payload types.
module mwm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input mwm_pkg::req_item_t req_item,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input mwm_pkg::rsp_item_t rsp_item
);
    import mwm_pkg::*;

    logic [2:0] outstanding_reg;
    logic       req_fire, rsp_fire;
    req_item_t  last_req_reg;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Count transactions accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 3'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 3'(req_fire) - 3'(rsp_fire);
        end
    end

    // Keep the last request around for debug visibility
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            last_req_reg <= req_item;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("response dropped or changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 3'd0)
        else $error("response without an accepted request, last mode %0d", last_req_reg.mode);

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd2)
        else $error("more requests in flight than the response queue can hold");

    a_mark_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.map_updated |-> rsp_item.known_wall || rsp_item.known_open)
        else $error("map written but neither flag of the marked side is set");

endmodule

bind maze_wall_map mwm_checker u_mwm_checker (.*);
